@@ rtl/vppl_pkg.sv @@
// Package for the virtual parallel port link: action codes, frame flags and the decoded op word.
`default_nettype none

package vppl_pkg;

    // Action codes of an input word
    localparam logic [2:0] ACT_HOST  = 3'd0;
    localparam logic [2:0] ACT_STAT  = 3'd1;
    localparam logic [2:0] ACT_DATA  = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;
    localparam logic [2:0] ACT_END   = 3'd5;

    // Frame flags OR-ed into the control byte
    localparam logic [7:0] FLAG_NONE   = 8'h00;
    localparam logic [7:0] FLAG_STROBE = 8'h08;
    localparam logic [7:0] FLAG_REPLY  = 8'h10;
    localparam logic [7:0] FLAG_START  = 8'h40;
    localparam logic [7:0] FLAG_END    = 8'h80;

    // Host command byte layout
    localparam int unsigned CMD_ACK_BIT  = 3;
    localparam int unsigned CMD_LOAD_BIT = 4;
    localparam int unsigned CMD_SET_BIT  = 5;
    localparam int unsigned CMD_OR_BIT   = 6;
    localparam int unsigned CMD_CLR_BIT  = 7;

    localparam logic [2:0] LINE_MASK = 3'h7;
    localparam logic [3:0] ACK_BIT   = 4'h8;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One classified operation, ready for the back end to carry out
    typedef struct packed {
        logic       send_en;          // action may send a frame
        logic       send_if_changed;  // send only when state differs from the sent copy
        logic [7:0] flag;             // flag OR-ed into the frame control byte
        logic [3:0] line_clr;         // line bits to clear before setting
        logic [3:0] line_set;         // line bits to set
        logic [7:0] byte_msk;         // data byte bits to replace
        logic [7:0] byte_val;         // replacement data bits
        logic       ack_req;          // raise ack, reply, then drop ack
    } vppl_op_t;

endpackage

`default_nettype wire

@@ rtl/vppl_front.sv @@
// Front end: accept input words and classify them into masked line and data updates.
`default_nettype none

module vppl_front
    import vppl_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [7:0] ctl_byte,
    input  logic [7:0] byte_value,
    input  logic [7:0] dir_mask,
    input  logic       queue_full,
    output logic       push,
    output vppl_op_t   push_op
);

    logic [2:0] cmd_bits;

    assign cmd_bits = ctl_byte[2:0] & LINE_MASK;
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_op = '0;
        case (action)
            ACT_HOST:
            begin
                push_op.send_en = 1'b1;
                push_op.flag    = FLAG_REPLY;
                if (ctl_byte != 8'h00)
                begin
                    if (ctl_byte[CMD_LOAD_BIT])
                    begin
                        push_op.byte_msk = 8'hFF;
                        push_op.byte_val = byte_value;
                    end
                    if (ctl_byte[CMD_SET_BIT])
                    begin
                        push_op.line_clr = 4'hF;
                        push_op.line_set = {1'b0, cmd_bits};
                    end
                    else if (ctl_byte[CMD_OR_BIT])
                    begin
                        push_op.line_set = {1'b0, cmd_bits};
                    end
                    else if (ctl_byte[CMD_CLR_BIT])
                    begin
                        push_op.line_clr = {1'b0, cmd_bits};
                    end
                    push_op.ack_req = ctl_byte[CMD_ACK_BIT];
                end
            end
            ACT_STAT:
            begin
                push_op.send_en         = 1'b1;
                push_op.send_if_changed = 1'b1;
                push_op.flag            = FLAG_NONE;
                push_op.line_clr        = {1'b0, dir_mask[2:0] & LINE_MASK};
                push_op.line_set        = {1'b0, byte_value[2:0] & dir_mask[2:0]};
            end
            ACT_DATA:
            begin
                push_op.send_en  = 1'b1;
                push_op.flag     = FLAG_STROBE;
                push_op.byte_msk = dir_mask;
                push_op.byte_val = byte_value;
            end
            ACT_START:
            begin
                push_op.send_en = 1'b1;
                push_op.flag    = FLAG_START;
            end
            ACT_END:
            begin
                push_op.send_en = 1'b1;
                push_op.flag    = FLAG_END;
            end
            ACT_READ:
            begin
                push_op = '0;
            end
            default:
            begin
                push_op = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/vppl_queue.sv @@
// Short FIFO of classified ops between the front end and the back end.
`default_nettype none

module vppl_queue
    import vppl_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  vppl_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output vppl_op_t head_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    vppl_op_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vppl_back.sv @@
// Back end: apply ops to the port state, decide on frames and hold the result word.
`default_nettype none

module vppl_back
    import vppl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       link_open,
    input  logic       head_valid,
    input  vppl_op_t   head_op,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_ctl,
    output logic [7:0] tx_data,
    output logic       ack_pulse,
    output logic [3:0] status_now,
    output logic [7:0] data_now
);

    logic [3:0] line_reg;
    logic [3:0] line_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic [3:0] sent_line_reg;
    logic [7:0] sent_data_reg;
    logic       out_valid_reg;
    logic [7:0] tx_ctl_reg;
    logic [7:0] tx_data_reg;
    logic       tx_valid_reg;
    logic       ack_reg;
    logic [3:0] line_upd;
    logic       changed;
    logic       fire;

    // Take the head op when the result slot is free or being drained
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        line_upd = (line_reg & ~head_op.line_clr) | head_op.line_set;
        if (head_op.ack_req)
        begin
            line_upd = line_upd | ACK_BIT;
        end
        data_next = (data_reg & ~head_op.byte_msk) | (head_op.byte_val & head_op.byte_msk);
        changed   = (line_upd != sent_line_reg) || (data_next != sent_data_reg);
        fire      = link_open && head_op.send_en && (!head_op.send_if_changed || changed);
        line_next = head_op.ack_req ? (line_upd & ~ACK_BIT) : line_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            data_reg      <= '0;
            sent_line_reg <= '0;
            sent_data_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                line_reg <= line_next;
                data_reg <= data_next;
                if (fire)
                begin
                    sent_line_reg <= line_upd;
                    sent_data_reg <= data_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tx_valid_reg <= fire;
            tx_ctl_reg   <= fire ? ({4'h0, line_upd} | head_op.flag) : 8'h00;
            tx_data_reg  <= fire ? data_next : 8'h00;
            ack_reg      <= head_op.ack_req;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = tx_valid_reg;
    assign tx_ctl     = tx_ctl_reg;
    assign tx_data    = tx_data_reg;
    assign ack_pulse  = ack_reg;
    assign status_now = line_reg;
    assign data_now   = data_reg;

endmodule

`default_nettype wire

@@ rtl/virtual_parallel_port_link_unit.sv @@
// Top level of the virtual parallel port link: front end, op queue, back end and link register.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | action, ctl_byte, byte_value, dir_mask
//  result   | out_valid/ out_stall | tx_valid, tx_ctl, tx_data, ack_pulse,
//           |                      | status_now, data_now
//  config   | cfg_valid/ cfg_ready | cfg_data (link_open)
//
// One input word is taken per cycle while in_stall is low; each word gives exactly one
// result word. A word passes through the op queue, then the back end's result register.
// The back end's state update (masked line and data merge plus a compare against the sent
// copies) sets the rate of one word per clock while the result is not stalled.
// Reset clears the line bits, data byte, sent copies, link_open and the queue.
// A stalled result holds; the queue takes up to QUEUE_DEPTH words, then in_stall rises.
`default_nettype none

module virtual_parallel_port_link_unit
    import vppl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [7:0] ctl_byte,
    input  logic [7:0] byte_value,
    input  logic [7:0] dir_mask,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_ctl,
    output logic [7:0] tx_data,
    output logic       ack_pulse,
    output logic [3:0] status_now,
    output logic [7:0] data_now,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic     link_open_reg;
    logic     queue_full;
    logic     push;
    vppl_op_t push_op;
    logic     pop;
    logic     head_valid;
    vppl_op_t head_op;

    // Always take config words; they must arrive only while the block is idle, which is up to the sender
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_open_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            link_open_reg <= cfg_data;
        end
    end

    // Classify the input word into a masked update and a send rule
    vppl_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .ctl_byte   (ctl_byte),
        .byte_value (byte_value),
        .dir_mask   (dir_mask),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    // Decouple the front from a stalled back end
    vppl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Apply the op, decide on the frame, hold the result word
    vppl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_open  (link_open_reg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_ctl     (tx_ctl),
        .tx_data    (tx_data),
        .ack_pulse  (ack_pulse),
        .status_now (status_now),
        .data_now   (data_now)
    );

endmodule

`default_nettype wire

@@ rtl/vppl_checker.sv @@
// Port-level checker for the virtual parallel port link, bound to the top level.
`default_nettype none

module vppl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       tx_valid,
    input logic [7:0] tx_ctl,
    input logic [7:0] tx_data,
    input logic       ack_pulse,
    input logic [3:0] status_now,
    input logic [7:0] data_now
);

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx_ctl) && $stable(tx_data)
            && $stable(status_now) && $stable(data_now))
        else $error("stalled result word changed");

    // No frame means zero frame bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_ctl == 8'h00 && tx_data == 8'h00)
        else $error("frame bytes nonzero without a frame");

    // Ack is dropped after the reply
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_pulse |-> !status_now[3])
        else $error("ack line still set after reply");

    // A reply with ack shows the reply flag and the ack bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_pulse && tx_valid |-> tx_ctl[4] && tx_ctl[3])
        else $error("ack reply frame missing flag or ack bit");

    // Frame data is the data byte left after the step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> tx_data == data_now)
        else $error("frame data differs from data byte");

endmodule

bind virtual_parallel_port_link_unit vppl_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_valid   (tx_valid),
    .tx_ctl     (tx_ctl),
    .tx_data    (tx_data),
    .ack_pulse  (ack_pulse),
    .status_now (status_now),
    .data_now   (data_now)
);

`default_nettype wire

@@ tb/sv/virtual_parallel_port_link_unit_test.sv @@
// Self-checking testbench for the virtual parallel port link unit.
`default_nettype none

module virtual_parallel_port_link_unit_test;
    import vppl_pkg::*;

    // Action codes the block treats like a read: no state change, no frame
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest correct run
    localparam int unsigned LONG_HOLD    = 120;     // receiver hold-off, in cycles
    localparam int unsigned SETTLE_TICKS = 4;       // op queue and result register latency plus margin

    // One input word and one result word, in the block's own widths
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] ctl;
        logic [7:0] value;
        logic [7:0] mask;
    } port_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_ctl;
        logic [7:0] tx_data;
        logic       ack_pulse;
        logic [3:0] status_now;
        logic [7:0] data_now;
    } port_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] action = ACT_READ;
    logic [7:0] ctl_byte = 8'h00;
    logic [7:0] byte_value = 8'h00;
    logic [7:0] dir_mask = 8'h00;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       tx_valid;
    logic [7:0] tx_ctl;
    logic [7:0] tx_data;
    logic       ack_pulse;
    logic [3:0] status_now;
    logic [7:0] data_now;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    // Shadow of the port: lines, data byte, copies last sent to the peer, link state
    logic       link_up = 1'b0;
    logic [3:0] lines_q = 4'h0;
    logic [7:0] data_q = 8'h00;
    logic [3:0] sent_lines_q = 4'h0;
    logic [7:0] sent_data_q = 8'h00;

    port_result_t pending_results[$];

    // Traffic shaping shared between the stimulus and the receiver
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned acks_seen = 0;

    virtual_parallel_port_link_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .ctl_byte   (ctl_byte),
        .byte_value (byte_value),
        .dir_mask   (dir_mask),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_ctl     (tx_ctl),
        .tx_data    (tx_data),
        .ack_pulse  (ack_pulse),
        .status_now (status_now),
        .data_now   (data_now),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    // Hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d words still pending",
                     $time, cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Advance the shadow port by one word and return the result it must produce.
    // Frames go out only while the link is up; the sent copies follow real frames only.
    function automatic port_result_t advance_port(input port_word_t w);
        port_result_t r;
        logic [7:0]   flag;
        logic         try_send;
        logic         only_if_changed;
        logic [3:0]   line_sel;
        r = '0;
        flag = FLAG_NONE;
        try_send = 1'b0;
        only_if_changed = 1'b0;
        line_sel = {1'b0, w.ctl[2:0]};
        case (w.action)
            ACT_HOST:
            begin
                // A zero command byte changes nothing but still draws a reply
                if (w.ctl != 8'h00)
                begin
                    if (w.ctl[CMD_LOAD_BIT])
                        data_q = w.value;
                    // Set wins over OR, OR wins over clear
                    if (w.ctl[CMD_SET_BIT])
                        lines_q = line_sel;
                    else if (w.ctl[CMD_OR_BIT])
                        lines_q = lines_q | line_sel;
                    else if (w.ctl[CMD_CLR_BIT])
                        lines_q = lines_q & ~line_sel;
                    if (w.ctl[CMD_ACK_BIT])
                    begin
                        r.ack_pulse = 1'b1;
                        lines_q = lines_q | ACK_BIT;
                    end
                end
                flag = FLAG_REPLY;
                try_send = 1'b1;
            end
            ACT_STAT:
            begin
                // Only the low three mask bits steer the lines
                line_sel = {1'b0, w.mask[2:0]};
                lines_q = ({1'b0, w.value[2:0]} & line_sel) | (lines_q & ~line_sel);
                try_send = 1'b1;
                only_if_changed = 1'b1;
            end
            ACT_DATA:
            begin
                data_q = (w.value & w.mask) | (data_q & ~w.mask);
                flag = FLAG_STROBE;
                try_send = 1'b1;
            end
            ACT_START:
            begin
                flag = FLAG_START;
                try_send = 1'b1;
            end
            ACT_END:
            begin
                flag = FLAG_END;
                try_send = 1'b1;
            end
            default: ;
        endcase
        if (try_send && link_up &&
            !(only_if_changed && lines_q == sent_lines_q && data_q == sent_data_q))
        begin
            r.tx_valid = 1'b1;
            r.tx_ctl = {4'h0, lines_q} | flag;
            r.tx_data = data_q;
            sent_lines_q = lines_q;
            sent_data_q = data_q;
        end
        // The ack line is only up for the reply frame
        if (r.ack_pulse)
            lines_q = lines_q & ~ACK_BIT;
        r.status_now = lines_q;
        r.data_now = data_q;
        return r;
    endfunction

    // Result receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (burst_left != 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            burst_left = $urandom_range(1, 5) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        port_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing pending, tx_ctl %0h data_now %0h",
                         $time, tx_ctl, data_now);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("tx_valid", {7'h00, want.tx_valid}, {7'h00, tx_valid});
                check_field("tx_ctl", want.tx_ctl, tx_ctl);
                check_field("tx_data", want.tx_data, tx_data);
                check_field("ack_pulse", {7'h00, want.ack_pulse}, {7'h00, ack_pulse});
                check_field("status_now", {4'h0, want.status_now}, {4'h0, status_now});
                check_field("data_now", want.data_now, data_now);
                words_checked++;
                if (tx_valid === 1'b1)
                    frames_seen++;
                if (ack_pulse === 1'b1)
                    acks_seen++;
            end
        end
    end

    // Offer one word and hold it until taken. Valid stays high on return so that
    // back-to-back words need no gap; anything that lets time pass drops it first.
    task automatic send_word(input port_word_t w);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.action;
        ctl_byte <= w.ctl;
        byte_value <= w.value;
        dir_mask <= w.mask;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(advance_port(w));
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [7:0] ctl,
                               input logic [7:0] value, input logic [7:0] mask);
        port_word_t w;
        w.action = act;
        w.ctl = ctl;
        w.value = value;
        w.mask = mask;
        send_word(w);
    endtask

    // Drop valid and wait until every pending result is in, then let the pipe settle
    task automatic drain_link;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write link_open; called only once the block is idle
    task automatic set_link(input logic open);
        drain_link();
        cfg_valid <= 1'b1;
        cfg_data <= open;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        link_up = open;
    endtask

    // Mostly line and data traffic; status writes often echo the current lines
    function automatic port_word_t random_word();
        port_word_t  w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.action = ACT_HOST;
        else if (pick < 60)
            w.action = ACT_STAT;
        else if (pick < 78)
            w.action = ACT_DATA;
        else if (pick < 85)
            w.action = ACT_READ;
        else if (pick < 90)
            w.action = ACT_START;
        else if (pick < 95)
            w.action = ACT_END;
        else
            w.action = 3'($urandom_range(ACT_SPARE6, ACT_SPARE7));
        w.ctl = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0)
            w.ctl = 8'h00;
        w.value = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: w.mask = 8'h00;
            1: w.mask = 8'hFF;
            default: w.mask = 8'($urandom_range(0, 255));
        endcase
        if (w.action == ACT_STAT && $urandom_range(0, 2) == 0)
            w.value = {4'h0, lines_q};
        return w;
    endfunction

    task automatic run_random(input int unsigned count, input bit allow_idle);
        for (int unsigned i = 0; i < count; i++)
        begin
            // Alternate stretches with and without idling
            if (i % 100 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            send_word(random_word());
        end
        idle_on = allow_idle;
    endtask

    // Link closed after reset: state moves and acks pulse, but no frame leaves
    task automatic test_closed_link;
        send_fields(ACT_READ, 8'h00, 8'h00, 8'h00);
        send_fields(ACT_HOST, 8'h3D, 8'h5A, 8'h00);
        send_fields(ACT_DATA, 8'h00, 8'hC3, 8'hF0);
        send_fields(ACT_START, 8'h00, 8'h00, 8'h00);
        send_fields(ACT_END, 8'h00, 8'h00, 8'h00);
        drain_link();
    endtask

    // Every action and command form once the link is up
    task automatic test_directed_open;
        set_link(1'b1);
        // stale sent copies: a no-op status write still has to send
        send_fields(ACT_STAT, 8'h00, 8'h00, 8'h00);
        send_fields(ACT_STAT, 8'h00, 8'hFF, 8'h00);
        send_fields(ACT_READ, 8'hFF, 8'hFF, 8'hFF);
        send_fields(ACT_HOST, 8'h00, 8'hFF, 8'hFF);
        send_fields(ACT_HOST, 8'h37, 8'hFF, 8'h00);
        send_fields(ACT_HOST, 8'h85, 8'h00, 8'h00);
        send_fields(ACT_HOST, 8'h44, 8'h00, 8'h00);
        send_fields(ACT_HOST, 8'h08, 8'h00, 8'h00);
        send_fields(ACT_HOST, 8'hFF, 8'h00, 8'hFF);
        send_fields(ACT_HOST, 8'hC3, 8'h11, 8'h00);
        send_fields(ACT_HOST, 8'h9F, 8'hEE, 8'h00);
        send_fields(ACT_STAT, 8'h00, 8'hFF, 8'hFF);
        send_fields(ACT_STAT, 8'h00, 8'hFF, 8'hFF);
        send_fields(ACT_STAT, 8'h00, 8'h00, 8'hF8);
        send_fields(ACT_STAT, 8'h00, 8'h00, 8'h07);
        send_fields(ACT_DATA, 8'h00, 8'hFF, 8'h00);
        send_fields(ACT_DATA, 8'h00, 8'hA5, 8'hFF);
        send_fields(ACT_DATA, 8'h00, 8'h00, 8'hF0);
        send_fields(ACT_START, 8'h00, 8'h00, 8'h00);
        send_fields(ACT_END, 8'h00, 8'h00, 8'h00);
        send_fields(ACT_SPARE6, 8'hFF, 8'hFF, 8'hFF);
        send_fields(ACT_SPARE7, 8'hFF, 8'hFF, 8'hFF);
        drain_link();
    endtask

    // Hold the receiver off while words keep coming, so the queue fills and stalls input
    task automatic test_backpressure;
        hold_req = 1'b1;
        run_random(40, 1'b1);
        drain_link();
    endtask

    // Pause the sender until everything is out, several times in a row
    task automatic test_sender_pause;
        for (int unsigned i = 0; i < 4; i++)
        begin
            run_random(10, 1'b1);
            drain_link();
        end
    endtask

    // Closing the link mid-session leaves the sent copies stale; reopen and catch up
    task automatic test_link_toggle;
        set_link(1'b0);
        run_random(150, 1'b1);
        hold_req = 1'b1;
        run_random(30, 1'b1);
        set_link(1'b1);
        send_fields(ACT_STAT, 8'h00, 8'h00, 8'h00);
        run_random(450, 1'b1);
        set_link(1'b0);
        set_link(1'b1);
        run_random(150, 1'b1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_closed_link();
        test_directed_open();
        run_random(600, 1'b1);
        test_backpressure();
        test_sender_pause();
        test_link_toggle();

        // Last stretch runs at full rate on both sides
        drain_link();
        idle_on = 1'b0;
        run_random(300, 1'b0);
        drain_link();

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_results.size());
            mismatches++;
        end
        $display("Checked %0d result words: %0d frames to the peer, %0d ack pulses,",
                 words_checked, frames_seen, acks_seen);
        $display("link open and closed, stalls on both sides, %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

@@ virtual_parallel_port_link_unit.f @@
rtl/vppl_pkg.sv
rtl/vppl_front.sv
rtl/vppl_queue.sv
rtl/vppl_back.sv
rtl/virtual_parallel_port_link_unit.sv
rtl/vppl_checker.sv
tb/sv/virtual_parallel_port_link_unit_test.sv
